FILE: rtl/stsi_pkg.sv
// Shared types and constants for the sorted tuple set insert block.
package stsi_pkg;

  // Fixed port widths.
  localparam int IN_ELEM_W    = 16;
  localparam int NUM_IN_ELEMS = 4;
  localparam int OUT_CNT_W    = 9;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 3;

  // Width of the effective arity, which reaches at most seven.
  localparam int ARITY_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SYMMETRIC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ARITY     = 1'b1;

  localparam logic [CFG_DATA_W-1:0] ARITY_RESET = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT,
    ST_CMP,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  // Control broadcast to every table cell.
  typedef struct packed {
    logic cmp_en;
    logic shift_en;
  } cell_ctl_t;

  // Control for the key sorter.
  typedef struct packed {
    logic load;
    logic step;
    logic odd;
  } sort_ctl_t;

endpackage

FILE: rtl/stsi_cell.sv
// One table cell: holds one stored tuple, compares it with the key, shifts on insert.
module stsi_cell #(
  parameter int MAX_ARITY = 4,
  parameter int ELEM_BITS = 16,
  parameter int CW        = 9,
  parameter int IDX       = 0
) (
  input  logic                                 clk,
  input  stsi_pkg::cell_ctl_t                  ctl,
  input  logic [CW-1:0]                        pos,
  input  logic [stsi_pkg::ARITY_W-1:0]         arity,
  input  logic [MAX_ARITY-1:0][ELEM_BITS-1:0]  key,
  input  logic [MAX_ARITY-1:0][ELEM_BITS-1:0]  prev_entry,
  output logic [MAX_ARITY-1:0][ELEM_BITS-1:0]  entry,
  output logic                                 key_gt,
  output logic                                 key_lt
);

  logic key_gt_c;
  logic key_lt_c;

  // The lowest differing element within the arity decides the order.
  always_comb begin
    key_gt_c = 1'b0;
    key_lt_c = 1'b0;
    for (int k = MAX_ARITY - 1; k >= 0; k--) begin
      if (k < int'(arity) && key[k] != entry[k]) begin
        key_gt_c = key[k] > entry[k];
        key_lt_c = key[k] < entry[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      if (CW'(IDX) > pos) begin
        entry <= prev_entry;
      end else if (CW'(IDX) == pos) begin
        entry <= key;
      end
    end
    if (ctl.cmp_en) begin
      key_gt <= key_gt_c;
      key_lt <= key_lt_c;
    end
  end

endmodule

FILE: rtl/stsi_key_sort.sv
// Key register with an odd-even transposition sorter, one phase per cycle.
module stsi_key_sort #(
  parameter int MAX_ARITY = 4,
  parameter int ELEM_BITS = 16
) (
  input  logic                                 clk,
  input  stsi_pkg::sort_ctl_t                  ctl,
  input  logic [stsi_pkg::ARITY_W-1:0]         arity,
  input  logic [MAX_ARITY-1:0][ELEM_BITS-1:0]  in_key,
  output logic [MAX_ARITY-1:0][ELEM_BITS-1:0]  key
);

  logic [MAX_ARITY-1:0][ELEM_BITS-1:0] key_swapped;

  // Pairs of one parity are disjoint, so all of them exchange at once.
  // Elements at or beyond the arity stay out of the sort.
  always_comb begin
    key_swapped = key;
    for (int j = 0; j < MAX_ARITY - 1; j++) begin
      if ((j & 1) == int'(ctl.odd) && (j + 1) < int'(arity) && key[j] > key[j+1]) begin
        key_swapped[j]   = key[j+1];
        key_swapped[j+1] = key[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key <= in_key;
    end else if (ctl.step) begin
      key <= key_swapped;
    end
  end

endmodule

FILE: rtl/sorted_tuple_set_insert.sv
// Top level of the sorted tuple set: control sequencer, search and the chain of table cells.
//
// The block keeps a duplicate-free table of tuples, sorted lexicographically, in a
// chain of cells, one cell per entry. Each accepted word is one tuple plus a mode bit.
// Only the first arity_in_use elements count (0 acts as 1, values above MAX_ARITY act
// as MAX_ARITY); the rest are zero. With symmetric set, the counted elements are sorted
// ascending first. A bisection over the held entries then reports whether the tuple is
// present and at what position, or else its insertion point. In insert mode an absent
// tuple is placed at that point by shifting every cell above it up by one, all at once,
// unless the table is full, in which case table_full is raised. One tuple is worked on
// at a time: the accept step, then one sort phase per counted element when symmetric
// mode is on and the arity is above one, a compare step in which every cell compares
// its entry with the key, the bisection steps (at most floor(log2(count)) + 2, so up to
// ten at 256 entries), and a finish step that writes the result word and performs the
// shift. The finish step is held for as long as the previous result word still waits on
// a stalled receiver. The result sits in an output register, so a new tuple is taken
// while the previous result still waits.
// The table needs no clearing after reset; only entries below the count are ever read.
module sorted_tuple_set_insert #(
  parameter int TABLE_DEPTH = 256,
  parameter int MAX_ARITY   = 4,
  parameter int ELEM_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port.
  input  logic                                 cfg_write,
  input  logic [stsi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [stsi_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Input channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 mode,
  input  logic [stsi_pkg::IN_ELEM_W-1:0]       elem_a,
  input  logic [stsi_pkg::IN_ELEM_W-1:0]       elem_b,
  input  logic [stsi_pkg::IN_ELEM_W-1:0]       elem_c,
  input  logic [stsi_pkg::IN_ELEM_W-1:0]       elem_d,
  // Output channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 found,
  output logic [stsi_pkg::OUT_CNT_W-1:0]       position,
  output logic                                 inserted,
  output logic                                 table_full,
  output logic [stsi_pkg::OUT_CNT_W-1:0]       entry_count
);

  // Count and position reach TABLE_DEPTH itself; a table index stops one below.
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int AW = stsi_pkg::ARITY_W;
  localparam int EW = stsi_pkg::IN_ELEM_W;
  localparam int OW = stsi_pkg::OUT_CNT_W;

  // Configuration registers.
  logic                            symmetric;
  logic [stsi_pkg::CFG_DATA_W-1:0] arity_reg;

  // Sequencer state.
  stsi_pkg::state_t state, state_next;
  logic [AW-1:0]    phase, phase_next;
  logic [CW-1:0]    first, first_next;
  logic [CW-1:0]    len, len_next;
  logic [CW-1:0]    pos_r, pos_r_next;
  logic             found_r, found_r_next;
  logic             mode_r;
  logic [CW-1:0]    count;

  // Datapath.
  logic [AW-1:0]                                          arity_ext;
  logic [AW-1:0]                                          arity_eff;
  logic [stsi_pkg::NUM_IN_ELEMS-1:0][EW-1:0]              in_elems;
  logic [stsi_pkg::NUM_IN_ELEMS-1:0][ELEM_BITS+EW-1:0]    in_ext;
  logic [MAX_ARITY-1:0][ELEM_BITS-1:0]                    in_key;
  logic [MAX_ARITY-1:0][ELEM_BITS-1:0]                    key;
  logic [TABLE_DEPTH-1:0][MAX_ARITY-1:0][ELEM_BITS-1:0]   entries;
  logic [TABLE_DEPTH-1:0]                                 key_gt_vec;
  logic [TABLE_DEPTH-1:0]                                 key_lt_vec;

  logic [CW-1:0]      half;
  logic [CW-1:0]      mid;
  logic [IW-1:0]      mid_idx;
  logic               mid_gt;
  logic               mid_lt;
  logic               accept;
  logic               out_free;
  logic               finish;
  logic               has_room;
  logic               do_insert;
  logic               refuse;
  logic [CW-1:0]      count_after;
  logic [CW+OW-1:0]   pos_ext;
  logic [CW+OW-1:0]   cnt_ext;

  stsi_pkg::cell_ctl_t cell_ctl;
  stsi_pkg::sort_ctl_t sort_ctl;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      symmetric <= 1'b0;
      arity_reg <= stsi_pkg::ARITY_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        stsi_pkg::REG_SYMMETRIC: symmetric <= cfg_data[0];
        stsi_pkg::REG_ARITY:     arity_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective arity: zero acts as one, anything above MAX_ARITY is clamped.
  assign arity_ext = AW'(arity_reg);
  always_comb begin
    if (arity_ext == '0) begin
      arity_eff = AW'(1);
    end else if (arity_ext > AW'(MAX_ARITY)) begin
      arity_eff = AW'(MAX_ARITY);
    end else begin
      arity_eff = arity_ext;
    end
  end

  // Input key: each element is fitted to ELEM_BITS, and elements outside the arity
  // or beyond the four input fields are zero.
  assign in_elems = {elem_d, elem_c, elem_b, elem_a};

  for (genvar k = 0; k < MAX_ARITY; k++) begin : g_key
    if (k < stsi_pkg::NUM_IN_ELEMS) begin : g_field
      assign in_ext[k] = {{ELEM_BITS{1'b0}}, in_elems[k]};
      assign in_key[k] = (k < int'(arity_eff)) ? in_ext[k][ELEM_BITS-1:0] : '0;
    end else begin : g_zero
      assign in_key[k] = '0;
    end
  end

  for (genvar k = MAX_ARITY; k < stsi_pkg::NUM_IN_ELEMS; k++) begin : g_unused
    assign in_ext[k] = {{ELEM_BITS{1'b0}}, in_elems[k]};
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != stsi_pkg::ST_IDLE);

  assign sort_ctl.load = accept;
  assign sort_ctl.step = (state == stsi_pkg::ST_SORT);
  assign sort_ctl.odd  = phase[0];

  stsi_key_sort #(
    .MAX_ARITY (MAX_ARITY),
    .ELEM_BITS (ELEM_BITS)
  ) u_key_sort (
    .clk    (clk),
    .ctl    (sort_ctl),
    .arity  (arity_eff),
    .in_key (in_key),
    .key    (key)
  );

  // Bisection probe: the registered compare flags of the middle cell.
  assign half    = len >> 1;
  assign mid     = first + half;
  assign mid_idx = mid[IW-1:0];
  assign mid_gt  = key_gt_vec[mid_idx];
  assign mid_lt  = key_lt_vec[mid_idx];

  // Finish: the result word is written once the output register is free.
  assign out_free    = !out_valid || !out_stall;
  assign finish      = (state == stsi_pkg::ST_FINISH) && out_free;
  assign has_room    = count < CW'(TABLE_DEPTH);
  assign do_insert   = !found_r && mode_r && has_room;
  assign refuse      = !found_r && mode_r && !has_room;
  assign count_after = count + CW'(do_insert);

  assign cell_ctl.cmp_en   = (state == stsi_pkg::ST_CMP);
  assign cell_ctl.shift_en = finish && do_insert;

  always_comb begin
    state_next   = state;
    phase_next   = phase;
    first_next   = first;
    len_next     = len;
    pos_r_next   = pos_r;
    found_r_next = found_r;
    case (state)
      stsi_pkg::ST_IDLE: begin
        if (accept) begin
          phase_next = '0;
          if (symmetric && arity_eff > AW'(1)) begin
            state_next = stsi_pkg::ST_SORT;
          end else begin
            state_next = stsi_pkg::ST_CMP;
          end
        end
      end
      stsi_pkg::ST_SORT: begin
        phase_next = phase + AW'(1);
        if (phase == arity_eff - AW'(1)) begin
          state_next = stsi_pkg::ST_CMP;
        end
      end
      stsi_pkg::ST_CMP: begin
        first_next   = '0;
        len_next     = count;
        found_r_next = 1'b0;
        state_next   = stsi_pkg::ST_SEARCH;
      end
      stsi_pkg::ST_SEARCH: begin
        if (len == '0) begin
          pos_r_next = first;
          state_next = stsi_pkg::ST_FINISH;
        end else if (!mid_gt && !mid_lt) begin
          found_r_next = 1'b1;
          pos_r_next   = mid;
          state_next   = stsi_pkg::ST_FINISH;
        end else if (mid_gt) begin
          first_next = mid + CW'(1);
          len_next   = len - half - CW'(1);
        end else begin
          len_next = half;
        end
      end
      stsi_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = stsi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = stsi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stsi_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (cell_ctl.shift_en) begin
        count <= count_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    phase   <= phase_next;
    first   <= first_next;
    len     <= len_next;
    pos_r   <= pos_r_next;
    found_r <= found_r_next;
    if (accept) begin
      mode_r <= mode;
    end
  end

  // The chain of cells. Cell zero never takes from a lower neighbor, so the key
  // stands in for its missing neighbor.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      stsi_cell #(
        .MAX_ARITY (MAX_ARITY),
        .ELEM_BITS (ELEM_BITS),
        .CW        (CW),
        .IDX       (i)
      ) u_cell (
        .clk        (clk),
        .ctl        (cell_ctl),
        .pos        (pos_r),
        .arity      (arity_eff),
        .key        (key),
        .prev_entry (key),
        .entry      (entries[i]),
        .key_gt     (key_gt_vec[i]),
        .key_lt     (key_lt_vec[i])
      );
    end else begin : g_body
      stsi_cell #(
        .MAX_ARITY (MAX_ARITY),
        .ELEM_BITS (ELEM_BITS),
        .CW        (CW),
        .IDX       (i)
      ) u_cell (
        .clk        (clk),
        .ctl        (cell_ctl),
        .pos        (pos_r),
        .arity      (arity_eff),
        .key        (key),
        .prev_entry (entries[i-1]),
        .entry      (entries[i]),
        .key_gt     (key_gt_vec[i]),
        .key_lt     (key_lt_vec[i])
      );
    end
  end

  // Output register. Position and count leave as nine-bit words.
  assign pos_ext = {{OW{1'b0}}, pos_r};
  assign cnt_ext = {{OW{1'b0}}, count_after};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      found       <= found_r;
      position    <= pos_ext[OW-1:0];
      inserted    <= do_insert;
      table_full  <= refuse;
      entry_count <= cnt_ext[OW-1:0];
    end
  end

endmodule

FILE: rtl/stsi_checker.sv
// Port-level checker for the sorted tuple set insert block, bound to its top level.
module stsi_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 found,
  input logic [stsi_pkg::OUT_CNT_W-1:0]       position,
  input logic                                 inserted,
  input logic                                 table_full,
  input logic [stsi_pkg::OUT_CNT_W-1:0]       entry_count
);

  // A stalled result word stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(position) && $stable(entry_count))
    else $error("result word changed while stalled");

  // At most one of hit, insert and refusal describes a word.
  a_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({found, inserted, table_full}) <= 1)
    else $error("conflicting outcome flags");

  // A hit lies inside the held entries.
  a_hit_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> position < entry_count)
    else $error("hit position beyond entry count");

  // An insertion point never lies past the held entries, and an insert lands inside.
  a_ins_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && inserted |-> position < entry_count && entry_count != '0)
    else $error("insert position beyond entry count");

endmodule

bind sorted_tuple_set_insert stsi_checker u_stsi_checker (.*);

FILE: test/sorted_tuple_set_insert_tb.sv
`timescale 1ns / 1ps
// Testbench for the sorted tuple set insert block: directed and random search/insert traffic.
//
// The bench keeps its own copy of the tuple table and of the two configuration registers.
// Every word accepted on the input channel is run through that copy right away, and the
// outcome it should produce is queued. Every word accepted on the output channel is then
// compared, field by field, with the oldest queued outcome.
//
// Traffic starts with a short directed list at the reset configuration and a few other
// settings. Then comes a series of random phases, each with its own symmetric and arity
// setting, the out-of-range arities included. Element values are drawn mostly from a tiny
// range so that lookups hit stored tuples and tuples stored under one arity are searched
// under another. After that the table is filled to the top with wide random tuples, and
// the last phases run against a full table, where every insert of a new tuple is refused.
//
// The table is never cleared: reset comes once, so the entry count only grows through
// the run. The phases are ordered with that in mind.
module sorted_tuple_set_insert_tb;

  localparam int TABLE_DEPTH   = 256;
  localparam int MAX_ARITY     = 4;
  localparam int ELEM_BITS     = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_COUNT   = 8;
  localparam int PHASE_WORDS   = 75;

  localparam int OUT_CNT_W  = stsi_pkg::OUT_CNT_W;
  localparam int CFG_IDX_W  = stsi_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = stsi_pkg::CFG_DATA_W;

  localparam logic MODE_SEARCH = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef logic [ELEM_BITS-1:0] elem_t;
  typedef logic [MAX_ARITY-1:0][ELEM_BITS-1:0] tuple_t;

  typedef struct packed {
    logic                 found;
    logic [OUT_CNT_W-1:0] position;
    logic                 inserted;
    logic                 table_full;
    logic [OUT_CNT_W-1:0] entry_count;
  } outcome_t;

  // Mirror of the tuple table with a queue of the outcomes still owed by the block.
  class tuple_set_scoreboard;
    tuple_t                entries [TABLE_DEPTH];
    int unsigned           held;
    logic                  symmetric;
    logic [CFG_DATA_W-1:0] arity;
    outcome_t              pending_outcomes [$];
    int unsigned           words_seen;
    int unsigned           errors;

    function new();
      held       = 0;
      symmetric  = 1'b0;
      arity      = stsi_pkg::ARITY_RESET;
      words_seen = 0;
      errors     = 0;
    endfunction

    function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == stsi_pkg::REG_SYMMETRIC) begin
        symmetric = data[0];
      end else begin
        arity = data;
      end
    endfunction

    // An arity of zero counts one element, and anything past the widest tuple counts all.
    function int counted_elems();
      if (arity == 0) return 1;
      if (arity > MAX_ARITY) return MAX_ARITY;
      return arity;
    endfunction

    // Lexicographic order of the key against one stored entry over the counted elements.
    function int order_against(tuple_t key, int idx, int n);
      for (int k = 0; k < n; k++) begin
        if (key[k] < entries[idx][k]) return -1;
        if (key[k] > entries[idx][k]) return 1;
      end
      return 0;
    endfunction

    // Runs one accepted word through the mirror table and queues the outcome it owes.
    function void note_tuple(logic m, elem_t a, elem_t b, elem_t c, elem_t d);
      tuple_t   key;
      elem_t    v;
      int       n, j, lo, span, half, mid, slot, order;
      logic     hit;
      outcome_t want;
      n = counted_elems();
      key = {d, c, b, a};
      for (int k = n; k < MAX_ARITY; k++) key[k] = '0;
      if (symmetric) begin
        for (int i = 1; i < n; i++) begin
          v = key[i];
          j = i;
          while (j > 0 && key[j-1] > v) begin
            key[j] = key[j-1];
            j--;
          end
          key[j] = v;
        end
      end
      // Same bisection as the block: the probe point and the shrink rule both matter
      // once entries stored under a wider arity are searched under a narrower one.
      lo   = 0;
      span = held;
      hit  = 1'b0;
      slot = 0;
      while (span > 0 && !hit) begin
        half  = span / 2;
        mid   = lo + half;
        order = order_against(key, mid, n);
        if (order == 0) begin
          hit  = 1'b1;
          slot = mid;
        end else if (order > 0) begin
          lo   = mid + 1;
          span = span - half - 1;
        end else begin
          span = half;
        end
      end
      if (!hit) slot = lo;
      want = '0;
      want.found    = hit;
      want.position = OUT_CNT_W'(slot);
      if (!hit && m == MODE_INSERT) begin
        if (held >= TABLE_DEPTH) begin
          want.table_full = 1'b1;
        end else begin
          for (int i = held; i > slot; i--) entries[i] = entries[i-1];
          entries[slot] = key;
          held++;
          want.inserted = 1'b1;
        end
      end
      want.entry_count = OUT_CNT_W'(held);
      pending_outcomes.insert(pending_outcomes.size(), want);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      $display("Mismatch on result word %0d, %s: got %0d, expected %0d",
               words_seen, what, got, want);
      errors++;
    endtask

    task check_word(outcome_t got);
      outcome_t want;
      words_seen++;
      if (pending_outcomes.size() == 0) begin
        report("word with nothing expected", 16'(got.position), 16'd0);
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.found !== want.found) report("found", 16'(got.found), 16'(want.found));
      if (got.position !== want.position)
        report("position", 16'(got.position), 16'(want.position));
      if (got.inserted !== want.inserted)
        report("inserted", 16'(got.inserted), 16'(want.inserted));
      if (got.table_full !== want.table_full)
        report("table_full", 16'(got.table_full), 16'(want.table_full));
      if (got.entry_count !== want.entry_count)
        report("entry_count", 16'(got.entry_count), 16'(want.entry_count));
    endtask
  endclass

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  cfg_write   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic                  mode        = 1'b0;
  elem_t                 elem_a      = '0;
  elem_t                 elem_b      = '0;
  elem_t                 elem_c      = '0;
  elem_t                 elem_d      = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic                  found;
  logic [OUT_CNT_W-1:0]  position;
  logic                  inserted;
  logic                  table_full;
  logic [OUT_CNT_W-1:0]  entry_count;

  tuple_set_scoreboard sb = new();

  int unsigned cycles       = 0;
  int unsigned burst_left   = 0;
  int unsigned pattern_left = 0;
  int unsigned stall_style  = 0;

  // Settings of the random phases, extremes and the out-of-range arities among them.
  logic                  phase_sym   [PHASE_COUNT] = '{0, 1, 0, 1, 0, 1, 0, 1};
  logic [CFG_DATA_W-1:0] phase_arity [PHASE_COUNT] = '{4, 4, 1, 0, 2, 3, 7, 5};

  sorted_tuple_set_insert #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_ARITY  (MAX_ARITY),
    .ELEM_BITS  (ELEM_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .elem_a     (elem_a),
    .elem_b     (elem_b),
    .elem_c     (elem_c),
    .elem_d     (elem_d),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .position   (position),
    .inserted   (inserted),
    .table_full (table_full),
    .entry_count(entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The run is cut off if it drags on far past any correct pace.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The receiver switches between styles now and then: no stall at all, coin-flip
  // stalls, and heavy stalling that keeps results waiting in the output register.
  always @(negedge clk) begin
    if (pattern_left == 0) begin
      stall_style  = $urandom_range(0, 2);
      pattern_left = $urandom_range(20, 120);
    end
    pattern_left = pattern_left - 1;
    case (stall_style)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 1) == 1);
      end
      default: begin
        out_stall <= ($urandom_range(0, 7) < 6);
      end
    endcase
  end

  // Every result word taken by the receiver goes straight to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_word({found, position, inserted, table_full, entry_count});
    end
  end

  // Mostly tiny values so that tuples collide; the rest covers the extremes and every bit.
  function automatic elem_t pick_elem();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return elem_t'($urandom_range(0, 3));
      5: return '0;
      6: return '1;
      7: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return elem_t'($urandom);
    endcase
  endfunction

  // Offers one word and returns at the falling edge after it was taken. Within a run of sends,
  // valid stays high across back-to-back words and drops only at the start of a gap between bursts.
  task automatic send_tuple(input logic m, input elem_t a, input elem_t b,
                            input elem_t c, input elem_t d);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    mode     <= m;
    elem_a   <= a;
    elem_b   <= b;
    elem_c   <= c;
    elem_d   <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tuple(m, a, b, c, d);
    burst_left = burst_left - 1;
    @(negedge clk);
  endtask

  task automatic send_random(input int unsigned insert_pct);
    logic m;
    m = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_SEARCH;
    send_tuple(m, pick_elem(), pick_elem(), pick_elem(), pick_elem());
  endtask

  // Drains the block before a register write: all owed words back, then a quiet stretch.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_outcomes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes the symmetric register, then the arity register. Only bit 0 of the symmetric word
  // counts, so the upper bits are random.
  task automatic set_config(input logic sym, input logic [CFG_DATA_W-1:0] ar);
    logic [CFG_DATA_W-1:0] sym_word;
    sym_word    = CFG_DATA_W'($urandom);
    sym_word[0] = sym;
    cfg_write <= 1'b1;
    cfg_index <= stsi_pkg::REG_SYMMETRIC;
    cfg_data  <= sym_word;
    @(negedge clk);
    sb.apply_config(stsi_pkg::REG_SYMMETRIC, sym_word);
    cfg_index <= stsi_pkg::REG_ARITY;
    cfg_data  <= ar;
    @(negedge clk);
    sb.apply_config(stsi_pkg::REG_ARITY, ar);
    cfg_write <= 1'b0;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Reset configuration: ordered tuples of four. A search on the empty table comes
    // first, then inserts at both ends, a hit in insert mode and a plain miss.
    send_tuple(MODE_SEARCH, 16'd1, 16'd2, 16'd3, 16'd4);
    send_tuple(MODE_INSERT, 16'd1, 16'd2, 16'd3, 16'd4);
    send_tuple(MODE_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tuple(MODE_INSERT, 16'd0, 16'd0, 16'd0, 16'd0);
    send_tuple(MODE_INSERT, 16'd1, 16'd2, 16'd3, 16'd4);
    send_tuple(MODE_SEARCH, 16'd1, 16'd2, 16'd3, 16'd5);
    send_tuple(MODE_INSERT, 16'd1, 16'd2, 16'd3, 16'd3);
    send_tuple(MODE_SEARCH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tuple(MODE_INSERT, 16'h8000, 16'd0, 16'hFFFF, 16'd1);

    // Symmetric mode: a reversed tuple has to find its sorted twin.
    settle();
    set_config(1'b1, 3'd4);
    send_tuple(MODE_SEARCH, 16'd4, 16'd3, 16'd2, 16'd1);
    send_tuple(MODE_INSERT, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
    send_tuple(MODE_INSERT, 16'd3, 16'd3, 16'd2, 16'd1);

    // An arity of zero acts as one: only the first element is compared and stored.
    settle();
    set_config(1'b0, 3'd0);
    send_tuple(MODE_SEARCH, 16'd1, 16'd9, 16'd9, 16'd9);
    send_tuple(MODE_INSERT, 16'd7, 16'hAAAA, 16'h5555, 16'd1);
    send_tuple(MODE_INSERT, 16'd7, 16'd1, 16'd1, 16'd1);

    // An arity past the widest tuple acts as the full width.
    settle();
    set_config(1'b1, 3'd7);
    send_tuple(MODE_INSERT, 16'd5, 16'd4, 16'hFFFF, 16'd0);
    send_tuple(MODE_SEARCH, 16'd5, 16'd4, 16'hFFFF, 16'd0);

    // Narrower arities while wider entries are held: trailing elements are dropped.
    settle();
    set_config(1'b0, 3'd2);
    send_tuple(MODE_INSERT, 16'd2, 16'd1, 16'hFFFF, 16'hFFFF);
    send_tuple(MODE_SEARCH, 16'd2, 16'd1, 16'd0, 16'd0);
    send_tuple(MODE_INSERT, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    settle();
    set_config(1'b1, 3'd3);
    send_tuple(MODE_INSERT, 16'd9, 16'd8, 16'd7, 16'd6);
    send_tuple(MODE_SEARCH, 16'd7, 16'd8, 16'd9, 16'd1);

    // Random phases, each under its own setting. About a third of the words insert,
    // which keeps the table from filling up before the last phase.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      settle();
      set_config(phase_sym[p], phase_arity[p]);
      repeat (PHASE_WORDS) send_random(35);
    end

    // Fill the table with wide random tuples, then keep inserting against a full table.
    settle();
    set_config(1'b0, 3'd4);
    while (sb.held < TABLE_DEPTH) begin
      send_tuple(MODE_INSERT, elem_t'($urandom), elem_t'($urandom),
                 elem_t'($urandom), elem_t'($urandom));
    end
    repeat (20) send_random(70);
    settle();
    set_config(1'b1, 3'd2);
    repeat (30) send_random(50);
    settle();
    set_config(1'b0, 3'd7);
    repeat (30) send_random(50);

    // Wait for every owed word, then a quiet stretch to catch anything extra.
    in_valid <= 1'b0;
    while (sb.pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
